/* rtl/dqr_pkg.sv */
`timescale 1ns / 1ps

package dqr_pkg;

  // Fixed field widths of the request and response items
  localparam int unsigned ActionW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_READ       = 3'd4,
    ACT_WRITE      = 3'd5
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Per-item control from the pointer unit to the storage and result path
  typedef struct packed {
    logic    mem_we;
    logic    mem_re;
    status_e status;
    logic    is_empty;
    logic    is_full;
  } ctrl_t;

endpackage

/* rtl/dqr_req_if.sv */
`timescale 1ns / 1ps

interface dqr_req_if
  import dqr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [ValueW-1:0]  entry_value;
  logic [PosW-1:0]    position;

  modport source (output valid, action, entry_value, position, input ready);
  modport sink   (input valid, action, entry_value, position, output ready);
endinterface

/* rtl/dqr_rsp_if.sv */
`timescale 1ns / 1ps

interface dqr_rsp_if
  import dqr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ValueW-1:0]  read_value;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  entry_count;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, read_value, status, entry_count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, read_value, status, entry_count, is_empty, is_full,
                  output ready);
endinterface

/* rtl/dqr_ptr.sv */
`timescale 1ns / 1ps

module dqr_ptr
  import dqr_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned PtrW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [ActionW-1:0] action_i,
  input  logic [PosW-1:0] position_i,
  output ctrl_t           ctrl_o,
  output logic [PtrW-1:0] addr_o,
  output logic [CntW-1:0] count_o
);

  localparam int unsigned SumW = PtrW + PosW + 1;

  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  logic            full, empty, in_range;
  logic [PtrW-1:0] head_next, head_prev, tail_next, tail_prev, at_addr;
  logic [SumW-1:0] at_sum, at_wrap;

  // Ring neighbors and occupancy flags
  assign full      = (count_q == CntW'(DEPTH));
  assign empty     = (count_q == '0);
  assign head_next = (head_q == PtrW'(DEPTH - 1)) ? '0 : head_q + PtrW'(1);
  assign head_prev = (head_q == '0) ? PtrW'(DEPTH - 1) : head_q - PtrW'(1);
  assign tail_next = (tail_q == PtrW'(DEPTH - 1)) ? '0 : tail_q + PtrW'(1);
  assign tail_prev = (tail_q == '0) ? PtrW'(DEPTH - 1) : tail_q - PtrW'(1);

  // Map a position from the front onto a slot; sum stays below twice the depth for an in-range position
  assign in_range = ({{CntW{1'b0}}, position_i} < {{PosW{1'b0}}, count_q});
  assign at_sum   = {{(PosW + 1){1'b0}}, head_q} + {{(PtrW + 1){1'b0}}, position_i};
  assign at_wrap  = (at_sum >= SumW'(DEPTH)) ? at_sum - SumW'(DEPTH) : at_sum;
  assign at_addr  = at_wrap[PtrW-1:0];

  // Decode the action into a slot access and pointer updates
  always_comb begin
    ctrl_o.mem_we = 1'b0;
    ctrl_o.mem_re = 1'b0;
    ctrl_o.status = ST_OK;
    addr_o        = at_addr;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    case (action_e'(action_i))
      ACT_PUSH_BACK: begin
        if (full) begin
          ctrl_o.status = ST_FULL;
        end else begin
          ctrl_o.mem_we = accept_i;
          addr_o        = tail_q;
          tail_d        = tail_next;
          count_d       = count_q + CntW'(1);
        end
      end
      ACT_PUSH_FRONT: begin
        if (full) begin
          ctrl_o.status = ST_FULL;
        end else begin
          ctrl_o.mem_we = accept_i;
          addr_o        = head_prev;
          head_d        = head_prev;
          count_d       = count_q + CntW'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          ctrl_o.status = ST_EMPTY;
        end else begin
          ctrl_o.mem_re = accept_i;
          addr_o        = tail_prev;
          tail_d        = tail_prev;
          count_d       = count_q - CntW'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          ctrl_o.status = ST_EMPTY;
        end else begin
          ctrl_o.mem_re = accept_i;
          addr_o        = head_q;
          head_d        = head_next;
          count_d       = count_q - CntW'(1);
        end
      end
      ACT_READ: begin
        if (!in_range) begin
          ctrl_o.status = ST_RANGE;
        end else begin
          ctrl_o.mem_re = accept_i;
        end
      end
      ACT_WRITE: begin
        if (!in_range) begin
          ctrl_o.status = ST_RANGE;
        end else begin
          ctrl_o.mem_we = accept_i;
        end
      end
      default: begin
      end
    endcase
    // Report the occupancy as it stands after this item
    ctrl_o.is_empty = (count_d == '0);
    ctrl_o.is_full  = (count_d == CntW'(DEPTH));
  end

  assign count_o = count_d;

  // Advance pointers on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

`ifndef ASSERT_OFF
  logic [PtrW:0] chk_sum, chk_tail;
  assign chk_sum  = {1'b0, head_q} + (PtrW + 1)'(count_q);
  assign chk_tail = (chk_sum >= (PtrW + 1)'(DEPTH)) ? chk_sum - (PtrW + 1)'(DEPTH) : chk_sum;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("occupancy exceeds depth");

  a_ring_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_tail[PtrW-1:0] == tail_q)
    else $error("tail does not sit count slots past head");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && ctrl_o.status != ST_OK |=> $stable(count_q) && $stable(head_q)
      && $stable(tail_q))
    else $error("rejected item changed the pointers");
`endif

endmodule

/* rtl/double_ended_queue_ring.sv */
`timescale 1ns / 1ps

// Double-ended queue of DEPTH entries held in a ring of one synchronous RAM.
// Requests arrive on req_i (action, entry_value, position); each request yields
// exactly one response on rsp_o (read_value, status, entry_count, is_empty,
// is_full), in request order. Actions: push back/front, pop back/front, read
// and write by position counted from the front. A push when full, a pop when
// empty or a position at or beyond the count is rejected with a status code
// and leaves the queue unchanged.
// An accepted request passes through the read stage and then the output
// register before its response shows on rsp_o.
// Throughput: one request per cycle while the receiver takes responses; head,
// tail and count update in the accept cycle and the RAM read port returns data in the cycle after.
// The RAM is never cleared; an entry is only read after it has been written.
// Reset empties the queue at once and drops any response in flight.
// When the receiver stalls, the response is held in the output register and
// one more request is taken into the read stage; req_i.ready then drops until
// the output drains.
module double_ended_queue_ring
  import dqr_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dqr_req_if.sink   req_i,
  dqr_rsp_if.source rsp_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ctrl_t                 ctrl;
  logic [PtrW-1:0]       addr;
  logic [CntW-1:0]       count;
  logic                  accept, in_ready, s1_adv;
  logic [DATA_WIDTH+ValueW-1:0] wval_ext;
  logic [DATA_WIDTH+ValueW-1:0] rdata_ext;
  logic [CntW+CountW-1:0] count_ext;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  logic                  s1_valid_q, s1_valid_d;
  logic                  s1_rd_q;
  status_e               s1_status_q;
  logic [CountW-1:0]     s1_count_q;
  logic                  s1_empty_q, s1_full_q;

  logic                  out_valid_q, out_valid_d;
  logic [ValueW-1:0]     out_value_q;
  status_e               out_status_q;
  logic [CountW-1:0]     out_count_q;
  logic                  out_empty_q, out_full_q;

  // Handshake: read stage drains into the output register when it is free
  assign s1_adv        = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign in_ready      = !s1_valid_q || s1_adv;
  assign req_i.ready   = in_ready;
  assign accept        = req_i.valid && in_ready;

  dqr_ptr #(
    .DEPTH (DEPTH)
  ) u_ptr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .action_i   (req_i.action),
    .position_i (req_i.position),
    .ctrl_o     (ctrl),
    .addr_o     (addr),
    .count_o    (count)
  );

  // Fit data and count to the fixed field widths
  assign wval_ext  = {{DATA_WIDTH{1'b0}}, req_i.entry_value};
  assign rdata_ext = {{ValueW{1'b0}}, rdata_q};
  assign count_ext = {{CountW{1'b0}}, count};

  // Slot RAM: at most one write or one registered read per accepted item
  always_ff @(posedge clk_i) begin
    if (ctrl.mem_we) begin
      mem_q[addr] <= wval_ext[DATA_WIDTH-1:0];
    end
    if (ctrl.mem_re) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Read stage and output register valid control
  assign s1_valid_d  = accept || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture item results while the RAM read is in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q     <= ctrl.mem_re;
      s1_status_q <= ctrl.status;
      s1_count_q  <= count_ext[CountW-1:0];
      s1_empty_q  <= ctrl.is_empty;
      s1_full_q   <= ctrl.is_full;
    end
  end

  // Load the output register with the read data merged in
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_value_q  <= s1_rd_q ? rdata_ext[ValueW-1:0] : '0;
      out_status_q <= s1_status_q;
      out_count_q  <= s1_count_q;
      out_empty_q  <= s1_empty_q;
      out_full_q   <= s1_full_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = out_value_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.is_empty    = out_empty_q;
  assign rsp_o.is_full     = out_full_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |-> !accept)
    else $error("read stage item overwritten");

  a_rdata_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_rd_q && !s1_adv |=> $stable(rdata_q))
    else $error("pending read data clobbered");

  a_access_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.mem_we || ctrl.mem_re |-> accept && !(ctrl.mem_we && ctrl.mem_re))
    else $error("RAM access without a single accepted item");
`endif

endmodule
